@@ rtl/first_fit_unit_allocator_defines.svh @@
// Assertion helpers for the unit allocator.
// Every check is sampled on clk_i and held off while rst_ni is low.
`ifndef FIRST_FIT_UNIT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define FFUA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffua check failed");

// Next-cycle implication
`define FFUA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffua check failed");

`endif

@@ rtl/ffua_pkg.sv @@
`default_nettype none

package ffua_pkg;

  // Field widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned SizeW  = 8;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned TotalW = 8;

  // Unit count in use after reset
  localparam logic [TotalW-1:0] TotalReset = 8'd100;

  // Request payload
  typedef struct packed {
    logic [IdW-1:0]   requester_id;
    logic [SizeW-1:0] size_req;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [IdW-1:0]   echo_id;
    logic             granted;
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] end_addr;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/ffua_chan_if.sv @@
`default_nettype none

// Valid/ready channel carrying one request or result per handshake
interface ffua_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/first_fit_unit_allocator.sv @@
// A request goes through a scan pass and, for a granted one, a marking pass before
// its result is registered; a failed request skips the marking pass.
// Throughput: one request at a time; the busy map is a rotating shift register
// read and marked one unit per cycle, so each pass covers all MAX_UNITS units.
// Reset (rst_ni low, async): every unit free, total_units = 100, no result
// pending. The result register lets a new request in while a result waits.
`default_nettype none

module first_fit_unit_allocator #(
  parameter int unsigned MAX_UNITS = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffua_pkg::TotalW-1:0]   cfg_wdata_i,
  ffua_chan_if.sink                          req_i,
  ffua_chan_if.source                        rsp_o
);

`include "first_fit_unit_allocator_defines.svh"

  localparam int unsigned CntW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned LimW = $clog2(MAX_UNITS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_UNITS - 1);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [MAX_UNITS-1:0]         map_q, map_d;
  logic [ffua_pkg::TotalW-1:0]  total_q;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [ffua_pkg::SizeW-1:0]   run_len_q, run_len_d;
  logic                         found_q, found_d;
  logic                         rsp_vld_q, rsp_vld_d;

  // Request context loaded on accept, then the found run bounds and the result
  logic [ffua_pkg::IdW-1:0]     id_q;
  logic [ffua_pkg::SizeW-1:0]   size_q;
  logic [LimW-1:0]              limit_q;
  logic                         size_ok_q;
  logic [CntW-1:0]              start_q, start_d;
  logic [CntW-1:0]              end_q, end_d;
  ffua_pkg::rsp_t               rsp_q, rsp_d;

  logic                         req_acc;
  logic                         rsp_load;
  logic [LimW-1:0]              limit_new;
  logic                         tap_free;
  logic                         in_range;
  logic                         mark_bit;
  logic [ffua_pkg::SizeW-1:0]   run_inc;

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_acc       = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  // Units in use, saturated to the map depth
  assign limit_new = (32'(total_q) > MAX_UNITS) ? LimW'(MAX_UNITS) : LimW'(total_q);

  // Unit at the tap is index cnt_q
  assign tap_free = ~map_q[0];
  assign in_range = (32'(cnt_q) < 32'(limit_q));
  assign run_inc  = ffua_pkg::SizeW'(run_len_q + 1'b1);
  assign mark_bit = (cnt_q >= start_q) && (cnt_q <= end_q);
  assign rsp_load = (state_q == S_DONE) && (!rsp_vld_q || rsp_o.ready);

  // Sequencer, bit-serial scan and marking
  always_comb begin
    state_d   = state_q;
    map_d     = map_q;
    cnt_d     = cnt_q;
    run_len_d = run_len_q;
    found_d   = found_q;
    start_d   = start_q;
    end_d     = end_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d   = S_SCAN;
          cnt_d     = '0;
          run_len_d = '0;
          found_d   = 1'b0;
        end
      end
      S_SCAN: begin
        map_d = {map_q[0], map_q[MAX_UNITS-1:1]};
        if (size_ok_q && !found_q && in_range) begin
          if (tap_free) begin
            if (run_len_q == '0) begin
              start_d = cnt_q;
            end
            run_len_d = run_inc;
            if (run_inc == size_q) begin
              found_d = 1'b1;
              end_d   = cnt_q;
            end
          end else begin
            run_len_d = '0;
          end
        end
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = found_d ? S_MARK : S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MARK: begin
        map_d = {map_q[0] | mark_bit, map_q[MAX_UNITS-1:1]};
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    rsp_d = rsp_q;
    rsp_vld_d = rsp_vld_q;
    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_vld_d        = 1'b1;
      rsp_d.echo_id    = id_q;
      rsp_d.granted    = found_q;
      rsp_d.start_addr = found_q ? ffua_pkg::AddrW'(start_q) : '0;
      rsp_d.end_addr   = found_q ? ffua_pkg::AddrW'(end_q) : '0;
    end
  end

  // Control state, busy map and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      map_q     <= '0;
      total_q   <= ffua_pkg::TotalReset;
      cnt_q     <= '0;
      run_len_q <= '0;
      found_q   <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      map_q     <= map_d;
      cnt_q     <= cnt_d;
      run_len_q <= run_len_d;
      found_q   <= found_d;
      rsp_vld_q <= rsp_vld_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    rsp_q   <= rsp_d;
    if (req_acc) begin
      id_q      <= req_i.payload.requester_id;
      size_q    <= req_i.payload.size_req;
      limit_q   <= limit_new;
      size_ok_q <= (req_i.payload.size_req != '0) &&
                   (32'(req_i.payload.size_req) <= 32'(limit_new));
    end
  end

  // Checks
  `FFUA_ASSERT_IMPL(a_mark_needs_fit, state_q == S_MARK, found_q && (start_q <= end_q))
  `FFUA_ASSERT_IMPL(a_run_bounded, state_q == S_SCAN, run_len_q <= size_q)
  `FFUA_ASSERT_IMPL(a_fail_zero_addr, rsp_vld_q && !rsp_q.granted,
                    (rsp_q.start_addr == '0) && (rsp_q.end_addr == '0))
  `FFUA_ASSERT_NEXT(a_load_valid, rsp_load, rsp_vld_q && (state_q == S_IDLE))

endmodule

`default_nettype wire

@@ tb/ffua_alloc_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result channels of the unit allocator, keeps its own
// copy of the busy map and unit count, and checks every result in order.
module ffua_alloc_checker #(
  parameter int unsigned MAX_UNITS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffua_pkg::TotalW-1:0]   cfg_wdata_i,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  ffua_pkg::req_t                req_payload_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  ffua_pkg::rsp_t                rsp_payload_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   granted_count_o,
  output int unsigned                   refused_count_o
);

  logic [MAX_UNITS-1:0]          busy_units;
  logic [ffua_pkg::TotalW-1:0]   total_units;
  ffua_pkg::rsp_t                alloc_expect_q[$];
  ffua_pkg::rsp_t                want;

  // Lowest run of free units, inside the units in use, exactly size long
  function automatic ffua_pkg::rsp_t first_fit(input ffua_pkg::req_t rq,
                                               input logic [MAX_UNITS-1:0] busy,
                                               input logic [ffua_pkg::TotalW-1:0] total);
    int unsigned    limit;
    int unsigned    size;
    int unsigned    run_start;
    int unsigned    run_len;
    ffua_pkg::rsp_t r;
    limit     = (total > MAX_UNITS) ? MAX_UNITS : total;
    size      = rq.size_req;
    run_start = 0;
    run_len   = 0;
    r         = '0;
    r.echo_id = rq.requester_id;
    if (size != 0 && size <= limit) begin
      for (int unsigned u = 0; u < limit && !r.granted; u++) begin
        if (!busy[u]) begin
          if (run_len == 0) run_start = u;
          run_len++;
          if (run_len == size) begin
            r.granted    = 1'b1;
            r.start_addr = ffua_pkg::AddrW'(run_start);
            r.end_addr   = ffua_pkg::AddrW'(run_start + size - 1);
          end
        end else begin
          run_len = 0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_units = '0;
      total_units = ffua_pkg::TotalReset;
      alloc_expect_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      granted_count_o  <= 0;
      refused_count_o  <= 0;
    end else begin
      if (cfg_we_i) total_units = cfg_wdata_i;

      // predict on request acceptance and mark the run busy
      if (req_valid_i && req_ready_i) begin
        want = first_fit(req_payload_i, busy_units, total_units);
        if (want.granted) begin
          for (int unsigned u = want.start_addr; u <= want.end_addr; u++) busy_units[u] = 1'b1;
        end
        alloc_expect_q = {alloc_expect_q, want};
      end

      // compare each result with the oldest prediction
      if (rsp_valid_i && rsp_ready_i) begin
        if (alloc_expect_q.size() == 0) begin
          $display("%0t: unexpected allocation result id=%h granted=%b start=%0d end=%0d",
                   $time, rsp_payload_i.echo_id, rsp_payload_i.granted,
                   rsp_payload_i.start_addr, rsp_payload_i.end_addr);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = alloc_expect_q.pop_front();
          if (rsp_payload_i.echo_id !== want.echo_id || rsp_payload_i.granted !== want.granted ||
              rsp_payload_i.start_addr !== want.start_addr ||
              rsp_payload_i.end_addr !== want.end_addr) begin
            $display("%0t: allocation mismatch: expected id=%h granted=%b start=%0d end=%0d",
                     $time, want.echo_id, want.granted, want.start_addr, want.end_addr);
            $display("%0t:                      actual   id=%h granted=%b start=%0d end=%0d",
                     $time, rsp_payload_i.echo_id, rsp_payload_i.granted,
                     rsp_payload_i.start_addr, rsp_payload_i.end_addr);
            mismatch_count_o <= mismatch_count_o + 1;
          end
          if (want.granted) granted_count_o <= granted_count_o + 1;
          else refused_count_o <= refused_count_o + 1;
        end
      end

      pending_o <= alloc_expect_q.size();
    end
  end

endmodule

@@ tb/tb_first_fit_unit_allocator.sv @@
`timescale 1ns / 1ps

module tb_first_fit_unit_allocator;

  localparam int unsigned MaxUnits    = 128;
  localparam int unsigned CycleLimit  = 4_000_000;
  localparam int unsigned PlanLen     = 13;
  localparam int unsigned PhaseItems  = 1800 / PlanLen;
  // unit counts for the random phases: shrink, grow, zero, saturate
  localparam logic [ffua_pkg::TotalW-1:0] TotalPlan [PlanLen] =
    '{8'd12, 8'd1, 8'd24, 8'd0, 8'd40, 8'd57, 8'd33, 8'd75, 8'd96, 8'd128, 8'd117,
      8'd200, 8'd255};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we;
  logic [ffua_pkg::TotalW-1:0]   cfg_wdata;
  bit                            calm;
  int unsigned                   cycles = 0;
  int unsigned                   requests_sent = 0;
  int unsigned                   settings_used = 0;
  int unsigned                   mismatches;
  int unsigned                   pending;
  int unsigned                   grants;
  int unsigned                   refusals;

  ffua_chan_if #(.payload_t(ffua_pkg::req_t)) req_ch ();
  ffua_chan_if #(.payload_t(ffua_pkg::rsp_t)) rsp_ch ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_unit_allocator #(
    .MAX_UNITS(MaxUnits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  ffua_alloc_checker #(
    .MAX_UNITS(MaxUnits)
  ) alloc_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_valid_i     (req_ch.valid),
    .req_ready_i     (req_ch.ready),
    .req_payload_i   (req_ch.payload),
    .rsp_valid_i     (rsp_ch.valid),
    .rsp_ready_i     (rsp_ch.ready),
    .rsp_payload_i   (rsp_ch.payload),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .granted_count_o (grants),
    .refused_count_o (refusals)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL first_fit_unit_allocator");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones
  initial begin : rsp_stall
    int unsigned hold;
    int unsigned pick;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        pick = $urandom_range(99);
        if (calm || pick < 50) begin
          rsp_ch.ready <= 1'b1;
          hold = $urandom_range(40, 1);
        end else if (pick < 96) begin
          rsp_ch.ready <= 1'b0;
          hold = $urandom_range(3, 1);
        end else begin
          rsp_ch.ready <= 1'b0;
          hold = $urandom_range(200, 40);
        end
      end
      hold--;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // Mostly small sizes so the map fills slowly across phases
  function automatic logic [ffua_pkg::SizeW-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return ffua_pkg::SizeW'($urandom_range(4, 1));
    if (pick < 80) return ffua_pkg::SizeW'($urandom_range(16, 5));
    if (pick < 88) return '0;
    return ffua_pkg::SizeW'($urandom_range(255));
  endfunction

  // Present one request; returns at the edge where it is accepted
  task automatic send_request(input logic [ffua_pkg::IdW-1:0] id,
                              input logic [ffua_pkg::SizeW-1:0] size);
    int unsigned gap;
    gap = calm ? 0 : idle_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= ffua_pkg::req_t'{requester_id: id, size_req: size};
    @(negedge clk_i);
    while (!req_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    requests_sent++;
  endtask

  // Hold off requests until every outstanding result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [ffua_pkg::TotalW-1:0] units);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= units;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset count of 100: zero size, oversize, then two small grants
    send_request(16'hFFFF, 8'd0);
    send_request(16'h0000, 8'hFF);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd101);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd1);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd2);
    // nothing in use
    write_total(8'd0);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd1);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd0);
    // every unit in use already taken
    write_total(8'd3);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd1);
    // too few free units, then an exact fit
    write_total(8'd5);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd3);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd2);
    // count above the map size saturates
    write_total(8'd255);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd128);
    send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), 8'd129);

    // random phases, one unit count each; some phases run without idling
    for (int unsigned p = 0; p < PlanLen; p++) begin
      write_total(TotalPlan[p]);
      calm = (p % 4 == 2);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(39) == 0) drain_results();
        send_request(ffua_pkg::IdW'($urandom_range(16'hFFFF)), random_size());
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (2 * MaxUnits + 8) @(posedge clk_i);

    $display("Run covered %0d requests under %0d unit-count settings (0 and 255 included),",
             requests_sent, settings_used + 1);
    $display("  %0d granted and %0d refused, with random gaps and result stalls.",
             grants, refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS first_fit_unit_allocator");
    end else begin
      $display("FAIL first_fit_unit_allocator");
    end
    $finish;
  end

endmodule
